// ===== rtl/core/prefix_varint_decoder_core_defines.svh =====
// Assertion macros for the prefix varint decoder core.
`ifndef PREFIX_VARINT_DECODER_CORE_DEFINES_SVH
`define PREFIX_VARINT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define PVD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pvd assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define PVD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pvd assertion failed");
`else
`define PVD_ASSERT_IMP(lbl, ante, cons)
`define PVD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/pvd_pkg.sv =====
// Types, constants and helper functions shared by the prefix varint decoder.
`default_nettype none

package pvd_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned ValueW = 64;
   localparam int unsigned LenW   = 4;
   localparam int unsigned CountW = 4;

   typedef logic [ByteW-1:0]  byte_type;
   typedef logic [ValueW-1:0] value_type;
   typedef logic [LenW-1:0]   len_type;
   typedef logic [CountW-1:0] count_type;

   // Prefix bit tested at each position of the first byte, top bit first.
   localparam byte_type PREFIX_BITS [ByteW] = '{
      8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
   };

   localparam len_type LEN_SINGLE = 4'd1;

   // Decoded first byte.
   typedef struct packed {
      count_type ones;      // extra bytes that follow
      byte_type  top_bits;  // value bits below the terminating zero
   } prefix_type;

   // One result transaction.
   typedef struct packed {
      value_type value;
      len_type   encoded_length;
      logic      too_big;
   } rsp_type;

   function automatic count_type leading_ones(input byte_type b);
      count_type n;
      logic      stop;
      n    = '0;
      stop = 1'b0;
      for (int i = 0; i < ByteW; i++) begin
         if (!stop && ((b & PREFIX_BITS[i]) != '0)) begin
            n = n + count_type'(1);
         end else begin
            stop = 1'b1;
         end
      end
      return n;
   endfunction

   // Keep the bits below the terminating zero; none when ones >= 7.
   function automatic byte_type top_mask(input count_type n);
      logic [CountW:0] sh;
      sh = {1'b0, n} + (CountW+1)'(1);
      return byte_type'(8'hFF >> sh);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pvd_in_stage.sv =====
// Input register of the prefix varint decoder.
`default_nettype none

module pvd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire pvd_pkg::byte_type req_data_byte,
   output logic                   req_ready,
   input  wire logic              take,
   output logic                   stage_valid,
   output pvd_pkg::byte_type      stage_byte
);

   logic              valid_ff, valid_in;
   pvd_pkg::byte_type byte_ff;
   logic              fire;

   assign req_ready = !valid_ff || take;
   assign fire      = req_valid && req_ready;

   always_comb begin
      if (fire) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= req_data_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pvd_prefix_decode.sv =====
// Leading-ones count and top-bit extraction for a first byte.
`default_nettype none

module pvd_prefix_decode (
   input  wire pvd_pkg::byte_type first_byte,
   output pvd_pkg::prefix_type prefix
);

   always_comb begin
      prefix.ones     = pvd_pkg::leading_ones(first_byte);
      prefix.top_bits = first_byte & pvd_pkg::top_mask(prefix.ones);
   end

endmodule

`default_nettype wire

// ===== rtl/core/pvd_accum.sv =====
// Decode state and byte accumulation of the prefix varint decoder.
`default_nettype none

module pvd_accum (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              narrow_mode,
   input  wire logic              in_valid,
   input  wire pvd_pkg::byte_type in_byte,
   input  wire logic              out_free,
   output logic                   take,
   output logic                   res_valid,
   output pvd_pkg::rsp_type       res
);

   pvd_pkg::count_type  rem_ff, rem_in;
   pvd_pkg::value_type  acc_ff, acc_in;
   pvd_pkg::len_type    len_ff, len_in;
   pvd_pkg::prefix_type prefix;
   pvd_pkg::value_type  shifted;
   logic                first;
   logic                complete;

   pvd_prefix_decode u_decode (
      .first_byte (in_byte),
      .prefix     (prefix)
   );

   assign first    = (rem_ff == '0);
   assign shifted  = {acc_ff[pvd_pkg::ValueW-pvd_pkg::ByteW-1:0], in_byte};
   assign complete = first ? (prefix.ones == '0) : (rem_ff == pvd_pkg::count_type'(1));

   // Take bytes that finish nothing at once; hold a completing byte until the output frees.
   assign take      = in_valid && (!complete || out_free);
   assign res_valid = in_valid && complete;

   always_comb begin
      res.value          = first ? pvd_pkg::value_type'(in_byte) : shifted;
      res.encoded_length = first ? pvd_pkg::LEN_SINGLE : len_ff;
      res.too_big        = narrow_mode && (res.value[pvd_pkg::ValueW-1:32] != '0);
   end

   always_comb begin
      rem_in = rem_ff;
      acc_in = acc_ff;
      len_in = len_ff;
      if (take) begin
         if (first) begin
            if (!complete) begin
               rem_in = prefix.ones;
               acc_in = pvd_pkg::value_type'(prefix.top_bits);
               len_in = pvd_pkg::len_type'(prefix.ones) + pvd_pkg::len_type'(1);
            end
         end else begin
            rem_in = rem_ff - pvd_pkg::count_type'(1);
            acc_in = complete ? '0 : shifted;
            len_in = complete ? '0 : len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         acc_ff <= '0;
         len_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         len_ff <= len_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pvd_out_stage.sv =====
// Result register of the prefix varint decoder.
`default_nettype none

module pvd_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire pvd_pkg::rsp_type   res,
   output logic                    out_free,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output pvd_pkg::value_type      rsp_value,
   output pvd_pkg::len_type        rsp_encoded_length,
   output logic                    rsp_too_big
);

   logic             valid_ff, valid_in;
   pvd_pkg::rsp_type res_ff;
   logic             fire;

   assign out_free = !valid_ff || rsp_ready;
   assign fire     = load && out_free;

   always_comb begin
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_value          = res_ff.value;
   assign rsp_encoded_length = res_ff.encoded_length;
   assign rsp_too_big        = res_ff.too_big;

endmodule

`default_nettype wire

// ===== rtl/core/prefix_varint_decoder_core.sv =====
// Top level of the prefix varint decoder: one byte in, one integer out when complete.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------------------
//   req     | in        | req_valid / req_ready  | req_data_byte[7:0]
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_value[63:0], rsp_encoded_length[3:0],
//           |           |                        | rsp_too_big
//   csr     | in        | csr_valid / csr_ready  | csr_narrow_mode
//
// One byte per cycle is sustained while the result register is free: a byte lands in the
// input register, is folded into the accumulator in the next cycle, and a completing byte
// loads the result register at that same edge, from which the result is shown on rsp.
// Reset (synchronous, active high) empties both registers and returns the decoder to
// awaiting a first byte; narrow mode resets to off.
// A stalled result register holds only completing bytes; bytes that merely extend the
// accumulator keep flowing. csr_ready is always high.
`default_nettype none
`include "prefix_varint_decoder_core_defines.svh"

module prefix_varint_decoder_core (
   input  wire logic               clock,
   input  wire logic               reset,
   // input byte stream
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pvd_pkg::byte_type  req_data_byte,
   // decoded integers
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pvd_pkg::value_type      rsp_value,
   output pvd_pkg::len_type        rsp_encoded_length,
   output logic                    rsp_too_big,
   // configuration write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_narrow_mode
);

   logic              narrow_mode_ff, narrow_mode_in;
   logic              stage_valid;
   pvd_pkg::byte_type stage_byte;
   logic              take;
   logic              out_free;
   logic              res_valid;
   pvd_pkg::rsp_type  res;

   // Configuration: take every transaction at once.
   assign csr_ready      = 1'b1;
   assign narrow_mode_in = (csr_valid && csr_ready) ? csr_narrow_mode : narrow_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_mode_ff <= 1'b0;
      end else begin
         narrow_mode_ff <= narrow_mode_in;
      end
   end

   // Input register: advance whenever the accumulator consumes the held byte.
   pvd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_ready     (req_ready),
      .take          (take),
      .stage_valid   (stage_valid),
      .stage_byte    (stage_byte)
   );

   // Decode state: count extra bytes, shift them in big-endian.
   pvd_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .narrow_mode (narrow_mode_ff),
      .in_valid    (stage_valid),
      .in_byte     (stage_byte),
      .out_free    (out_free),
      .take        (take),
      .res_valid   (res_valid),
      .res         (res)
   );

   // Result register: decouple the result side from the byte stream.
   pvd_out_stage u_out_stage (
      .clock              (clock),
      .reset              (reset),
      .load               (res_valid),
      .res                (res),
      .out_free           (out_free),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_value          (rsp_value),
      .rsp_encoded_length (rsp_encoded_length),
      .rsp_too_big        (rsp_too_big)
   );

   // Length of any delivered integer lies in one to nine bytes.
   `PVD_ASSERT_IMP(a_len_range, rsp_valid, rsp_encoded_length >= 4'd1 && rsp_encoded_length <= 4'd9)
   // A single-byte integer never carries more than seven value bits.
   `PVD_ASSERT_IMP(a_single_narrow, rsp_valid && rsp_encoded_length == 4'd1, rsp_value[63:7] == '0)
   // The flag only rises in narrow mode and only for values beyond 32 bits.
   `PVD_ASSERT_IMP(a_too_big, rsp_valid && rsp_too_big, narrow_mode_ff && rsp_value[63:32] != '0)
   // A configuration transaction lands in the mode register.
   `PVD_ASSERT_NEXT(a_cfg_write, csr_valid && csr_ready, narrow_mode_ff == $past(csr_narrow_mode))

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the prefix varint decoder core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_GAP        = 13;      // longest idle stretch either side draws
   localparam int HOLD_CYCLES    = 150;     // long receiver hold-off for the fill-up test
   localparam int LATENCY_CYCLES = 4;       // settle margin after the last result
   localparam int LIMIT_CYCLES   = 200_000; // watchdog, far above the slowest clean run

   // Clock, reset and every block input start at a known value.
   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   pvd_pkg::byte_type  req_data_byte   = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   pvd_pkg::value_type rsp_value;
   pvd_pkg::len_type   rsp_encoded_length;
   logic               rsp_too_big;
   logic               csr_valid       = 1'b0;
   logic               csr_ready;
   logic               csr_narrow_mode = 1'b0;

   always #4 clock = ~clock;

   prefix_varint_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_value          (rsp_value),
      .rsp_encoded_length (rsp_encoded_length),
      .rsp_too_big        (rsp_too_big),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_narrow_mode    (csr_narrow_mode)
   );

   // ------------------------------------------------------------------
   // Decoder prediction: a private copy of the framing state and of the
   // narrow-mode register, advanced on every accepted transaction.
   // ------------------------------------------------------------------
   pvd_pkg::count_type bytes_owed     = '0;   // extra bytes still due for the current integer
   pvd_pkg::value_type partial_value  = '0;   // value bits gathered so far
   pvd_pkg::len_type   integer_length = '0;   // full length of the integer in flight
   logic               narrow_flag    = 1'b0;
   pvd_pkg::rsp_type   decoded_queue[$];      // decoded integers not yet seen on rsp
   int                 fail_count     = 0;

   // Queue one decoded integer; flag it when narrow mode is on and it spills past 32 bits.
   task automatic push_decoded(input pvd_pkg::value_type v, input pvd_pkg::len_type len);
      pvd_pkg::rsp_type r;
      r.value          = v;
      r.encoded_length = len;
      r.too_big        = narrow_flag && (v > 64'hFFFF_FFFF);
      decoded_queue.push_back(r);
   endtask

   task automatic fold_byte(input pvd_pkg::byte_type b);
      int ones;
      ones = 0;
      if (bytes_owed == '0) begin
         // First byte: count the leading ones, which give the extra bytes to come.
         while (ones < 8 && b[7 - ones]) ones++;
         if (ones == 0) begin
            push_decoded(pvd_pkg::value_type'(b), pvd_pkg::LEN_SINGLE);
         end else begin
            // Keep only the bits below the terminating zero; an all-ones or
            // 0xFE first byte contributes nothing.
            partial_value  = pvd_pkg::value_type'(b) & (64'hFF >> (ones + 1));
            bytes_owed     = pvd_pkg::count_type'(ones);
            integer_length = pvd_pkg::len_type'(ones + 1);
         end
      end else begin
         // Continuation byte: shift in big-endian order.
         partial_value = {partial_value[55:0], b};
         bytes_owed    = bytes_owed - pvd_pkg::count_type'(1);
         if (bytes_owed == '0) begin
            push_decoded(partial_value, integer_length);
            partial_value  = '0;
            integer_length = '0;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample the handshakes on the rising edge (pre-edge values),
   // check each rsp transaction against the oldest prediction, then fold
   // in configuration and input bytes.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      pvd_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_queue.size() == 0) begin
               $error("unexpected rsp transaction: value %h length %0d too_big %0b",
                      rsp_value, rsp_encoded_length, rsp_too_big);
               fail_count++;
            end else begin
               want = decoded_queue.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_encoded_length !== want.encoded_length) begin
                  $error("encoded_length: expected %0d, actual %0d",
                         want.encoded_length, rsp_encoded_length);
                  fail_count++;
               end
               if (rsp_too_big !== want.too_big) begin
                  $error("too_big: expected %0b, actual %0b", want.too_big, rsp_too_big);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) narrow_flag = csr_narrow_mode;
         if (req_valid && req_ready) fold_byte(req_data_byte);
      end
   end

   // Watchdog: give up on a hung handshake.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Idle control shared by the sender and the receiver.
   // ------------------------------------------------------------------
   int sender_max_gap   = MAX_GAP;
   int receiver_max_gap = MAX_GAP;
   int hold_request     = 0;   // one-off long hold-off, picked up by the receiver
   int bytes_sent       = 0;

   function automatic int draw_gap(input int max_gap);
      return (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
   endfunction

   // Receiver: before each result, idle for a drawn number of cycles (or the long
   // hold-off when one is requested), then hold ready until a transaction lands.
   initial begin : receiver
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request > 0) begin
            gap          = hold_request;
            hold_request = 0;
         end else begin
            gap = draw_gap(receiver_max_gap);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ------------------------------------------------------------------
   // Sender side. send_byte returns in the step of acceptance with valid
   // still high, so a back-to-back byte keeps valid up without a glitch.
   // ------------------------------------------------------------------
   task automatic send_byte(input pvd_pkg::byte_type b);
      int gap;
      gap = draw_gap(sender_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Encode v with the given count of extra bytes; drop bits that the form cannot carry.
   task automatic send_integer(input int extra, input pvd_pkg::value_type v);
      pvd_pkg::value_type masked;
      pvd_pkg::byte_type  head;
      if (extra <= 6)      masked = v & ((64'd1 << (7 + 7 * extra)) - 64'd1);
      else if (extra == 7) masked = v & ((64'd1 << 56) - 64'd1);
      else                 masked = v;
      head = ~(8'hFF >> extra);
      if (extra <= 6) head = head | pvd_pkg::byte_type'(masked >> (8 * extra));
      send_byte(head);
      for (int i = extra - 1; i >= 0; i--) send_byte(masked[8*i +: 8]);
   endtask

   // Drop valid and let the monitor settle, then pad out any integer left open by noise
   // so that the decoder returns to awaiting a first byte.
   task automatic close_integer();
      req_valid <= 1'b0;
      @(posedge clock);
      repeat (bytes_owed) send_byte(pvd_pkg::byte_type'($urandom_range(255, 0)));
   endtask

   // Drain every outstanding result, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_queue.size() != 0);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   // Write narrow mode only once the decoder is between integers and drained.
   task automatic write_narrow(input logic mode);
      close_integer();
      wait_idle();
      csr_valid       <= 1'b1;
      csr_narrow_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Single-byte integers at both ends, and the largest two-byte form.
   task automatic test_single_byte();
      send_byte(8'h00);
      send_byte(8'h7F);
      send_integer(1, 64'h3FFF);
   endtask

   // All-ones first byte: eight extra bytes carry a full 64-bit value.
   task automatic test_all_ones_prefix();
      send_integer(8, '1);
   endtask

   // Either side of the 32-bit boundary with narrow mode on.
   task automatic test_narrow_boundary();
      write_narrow(1'b1);
      send_integer(4, 64'hFFFF_FFFF);
      send_integer(4, 64'h1_0000_0000);
   endtask

   // Hold rsp off for a long stretch while single-byte integers keep coming,
   // so that the decoder fills up and stalls req.
   task automatic test_output_backpressure();
      int saved_gap;
      saved_gap      = sender_max_gap;
      sender_max_gap = 0;
      hold_request   = HOLD_CYCLES;
      repeat (40) send_byte(pvd_pkg::byte_type'($urandom_range(127, 0)));
      sender_max_gap = saved_gap;
      close_integer();
      wait_idle();
   endtask

   // Mostly well-formed integers of every length with random magnitudes; the
   // rest is raw noise that lands wherever the framing happens to be.
   task automatic test_random_stream(input int byte_budget);
      int start;
      int pick;
      start = bytes_sent;
      while (bytes_sent - start < byte_budget) begin
         pick = $urandom_range(99, 0);
         if (pick < 85)
            send_integer($urandom_range(8, 0), {$urandom, $urandom} >> $urandom_range(63, 0));
         else if (pick < 93)
            send_byte(pvd_pkg::byte_type'($urandom_range(255, 0)));
         else
            send_byte(8'hFF);
      end
      close_integer();
      wait_idle();
   endtask

   initial begin : sequencer
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_single_byte();
      test_all_ones_prefix();
      test_narrow_boundary();

      write_narrow(1'b0);
      test_output_backpressure();
      test_random_stream(300);

      // Run flat out: no idling on either side.
      sender_max_gap   = 0;
      receiver_max_gap = 0;
      test_random_stream(300);

      sender_max_gap   = MAX_GAP;
      receiver_max_gap = MAX_GAP;
      write_narrow(1'b1);
      test_random_stream(300);

      close_integer();
      wait_idle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
